// ----- src/scba_pkg.sv -----
// Shared types, constants and size-class functions for the size-class bump allocator.
// Used by scba_ctrl, scba_dpath, size_class_bump_allocator and the sim files; depends on nothing.
`timescale 1ns / 1ps

package scba_pkg;

  localparam int SMALL_LIMIT     = 1024;
  localparam int ALLOC_CAP       = 65536;
  localparam int PAGE_SPAN       = 2097152;
  localparam int ADDR_BITS       = 48;
  localparam int BASE_SHIFT      = 4;
  localparam int SMALL_LOG2      = $clog2(SMALL_LIMIT);
  localparam int SMALL_CLS_COUNT = SMALL_LOG2 - BASE_SHIFT + 1;
  localparam int CLASS_COUNT     = SMALL_CLS_COUNT + 4 * ($clog2(ALLOC_CAP) - SMALL_LOG2);
  localparam int REQ_W           = 17;
  localparam int ALIGN_W         = 11;
  localparam int CLS_W           = 5;
  localparam int LOG_W           = 5;

  typedef enum logic [1:0] {
    ST_CURSOR = 2'd0,
    ST_REFILL = 2'd1,
    ST_OOM    = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

  // Index of the highest set bit; zero for a zero argument.
  function automatic logic [LOG_W-1:0] floor_log2(input logic [REQ_W-1:0] x);
    logic [LOG_W-1:0] n;
    n = '0;
    for (int k = 0; k < REQ_W; k++) begin
      if (x[k]) n = LOG_W'(k);
    end
    return n;
  endfunction

  // Size class of a request no larger than the allocation cap.
  function automatic logic [CLS_W-1:0] size_to_class(input logic [REQ_W-1:0] req);
    logic [REQ_W-1:0] m;
    logic [LOG_W-1:0] e;
    logic [REQ_W-1:0] top;
    logic [5:0]       c;
    m = req - REQ_W'(1);
    e = floor_log2(m);
    top = '0;
    if (req <= REQ_W'(SMALL_LIMIT)) begin
      if (req <= REQ_W'(1 << BASE_SHIFT)) begin
        c = '0;
      end else begin
        c = 6'(e) + 6'd1 - 6'(BASE_SHIFT);
      end
    end else begin
      top = m >> (e - LOG_W'(2));
      c = 6'(SMALL_CLS_COUNT) + (6'(e - LOG_W'(SMALL_LOG2)) << 2) + 6'(top[1:0]);
    end
    if (c > 6'(CLASS_COUNT - 1)) c = 6'(CLASS_COUNT - 1);
    return c[CLS_W-1:0];
  endfunction

  // Rounded object size of a class.
  function automatic logic [REQ_W-1:0] class_to_size(input logic [CLS_W-1:0] cls);
    logic [CLS_W-1:0] i;
    logic [LOG_W-1:0] sh;
    logic [REQ_W-1:0] sz;
    i = cls - CLS_W'(SMALL_CLS_COUNT);
    if (cls < CLS_W'(SMALL_CLS_COUNT)) begin
      sh = LOG_W'(cls) + LOG_W'(BASE_SHIFT);
      sz = REQ_W'(1) << sh;
    end else begin
      sh = LOG_W'(SMALL_LOG2 - 2) + LOG_W'(i[CLS_W-1:2]);
      sz = REQ_W'(4'd5 + 4'(i[1:0])) << sh;
    end
    return sz;
  endfunction

endpackage

// ----- src/scba_ctrl.sv -----
// Controller of the size-class bump allocator: handshakes and sequencing.
// Depends on scba_pkg; drives the datapath in scba_dpath through a command struct.
`timescale 1ns / 1ps

module scba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output scba_pkg::cmd_t  cmd
);

  scba_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scba_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    in_stall   = 1'b1;
    unique case (state_r)
      scba_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = scba_pkg::S_UPD;
        end
      end
      scba_pkg::S_UPD: begin
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = scba_pkg::S_IDLE;
        end
      end
      default: state_nxt = scba_pkg::S_IDLE;
    endcase
    out_valid_nxt = cmd.commit || (out_valid_r && out_stall);
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/scba_dpath.sv -----
// Datapath of the size-class bump allocator: class decode, cursor table and result register.
// Depends on scba_pkg; sequenced by scba_ctrl through a command struct.
`timescale 1ns / 1ps

module scba_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  scba_pkg::cmd_t                      cmd,
  input  logic [scba_pkg::REQ_W-1:0]          in_request_bytes,
  input  logic [scba_pkg::ALIGN_W-1:0]        in_alignment,
  input  logic                                in_page_offered,
  input  logic [scba_pkg::ADDR_BITS-1:0]      in_page_base,
  output logic [1:0]                          out_status,
  output logic [scba_pkg::ADDR_BITS-1:0]      out_address,
  output logic [scba_pkg::CLS_W-1:0]          out_size_class,
  output logic [scba_pkg::REQ_W-1:0]          out_object_size
);

  localparam logic [scba_pkg::ADDR_BITS-1:0] PAGE_OFS =
    scba_pkg::ADDR_BITS'(scba_pkg::PAGE_SPAN);

  logic [scba_pkg::ADDR_BITS-1:0] next_mem [scba_pkg::CLASS_COUNT];
  logic [scba_pkg::ADDR_BITS-1:0] base_mem [scba_pkg::CLASS_COUNT];
  logic [scba_pkg::CLASS_COUNT-1:0] vld_r;

  logic [scba_pkg::CLS_W-1:0]     cls_r;
  logic [scba_pkg::REQ_W-1:0]     size_r;
  logic                           over_r;
  logic                           offered_r;
  logic [scba_pkg::ADDR_BITS-1:0] page_r;
  logic                           hit_r;
  logic [scba_pkg::ADDR_BITS-1:0] rd_next_r;
  logic [scba_pkg::ADDR_BITS-1:0] rd_base_r;

  logic [1:0]                     status_r;
  logic [scba_pkg::ADDR_BITS-1:0] addr_r;
  logic [scba_pkg::CLS_W-1:0]     ocls_r;
  logic [scba_pkg::REQ_W-1:0]     osize_r;

  logic [scba_pkg::ALIGN_W-1:0]   align_c;
  logic [scba_pkg::REQ_W-1:0]     req;
  logic                           over;
  logic [scba_pkg::CLS_W-1:0]     cls;

  logic [scba_pkg::ADDR_BITS-1:0] cur_next;
  logic [scba_pkg::ADDR_BITS-1:0] cur_base;
  logic [scba_pkg::ADDR_BITS-1:0] size_a;
  logic                           room;
  logic                           wr;
  logic [scba_pkg::ADDR_BITS-1:0] new_next;
  logic [scba_pkg::ADDR_BITS-1:0] new_base;
  scba_pkg::status_t              status;

  always_comb begin
    align_c = (in_alignment > scba_pkg::ALIGN_W'(scba_pkg::SMALL_LIMIT)) ?
              scba_pkg::ALIGN_W'(scba_pkg::SMALL_LIMIT) : in_alignment;
    req  = (in_request_bytes > scba_pkg::REQ_W'(align_c)) ?
           in_request_bytes : scba_pkg::REQ_W'(align_c);
    over = req > scba_pkg::REQ_W'(scba_pkg::ALLOC_CAP);
    cls  = over ? scba_pkg::CLS_W'(scba_pkg::CLASS_COUNT - 1) : scba_pkg::size_to_class(req);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cls_r     <= cls;
      size_r    <= over ? scba_pkg::REQ_W'(scba_pkg::ALLOC_CAP) : scba_pkg::class_to_size(cls);
      over_r    <= over;
      offered_r <= in_page_offered;
      page_r    <= in_page_base;
      hit_r     <= vld_r[cls];
      rd_next_r <= next_mem[cls];
      rd_base_r <= base_mem[cls];
    end
  end

  always_comb begin
    cur_next = hit_r ? rd_next_r : '0;
    cur_base = hit_r ? rd_base_r : '0;
    size_a   = scba_pkg::ADDR_BITS'(size_r);
    room     = (cur_next - cur_base) >= size_a;
    wr       = 1'b0;
    new_next = cur_next;
    new_base = cur_base;
    status   = scba_pkg::ST_OOM;
    if (!over_r) begin
      if (room) begin
        wr       = 1'b1;
        new_next = cur_next - size_a;
        status   = scba_pkg::ST_CURSOR;
      end else if (offered_r) begin
        wr       = 1'b1;
        new_base = page_r;
        new_next = page_r + (PAGE_OFS - size_a);
        status   = scba_pkg::ST_REFILL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.commit && wr) begin
      vld_r[cls_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr) begin
      next_mem[cls_r] <= new_next;
      base_mem[cls_r] <= new_base;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= status;
      addr_r   <= wr ? new_next : '0;
      ocls_r   <= cls_r;
      osize_r  <= size_r;
    end
  end

  assign out_status      = status_r;
  assign out_address     = addr_r;
  assign out_size_class  = ocls_r;
  assign out_object_size = osize_r;

endmodule

// ----- src/size_class_bump_allocator.sv -----
// Top level of the size-class bump allocator; joins controller and datapath.
// Depends on scba_pkg, scba_ctrl and scba_dpath.
//
//   Channel  Ports                                               Direction
//   in       in_valid, in_stall, in_request_bytes, in_alignment,  request beat in
//            in_page_offered, in_page_base
//   out      out_valid, out_stall, out_status, out_address,      result beat out
//            out_size_class, out_object_size
//
// Each request is handled in order: a load step latches it, decodes its size class and reads that
// class's cursor entry; an update step then updates and writes back the entry and loads the result register.
// No new request is taken until the update is done, as a request may hit the same class's cursor.
// Reset is synchronous; it clears the controller and the per-class valid bits, so every
// class starts empty. A stalled result holds the update cycle until the result is taken.
`timescale 1ns / 1ps

module size_class_bump_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [scba_pkg::REQ_W-1:0]          in_request_bytes,
  input  logic [scba_pkg::ALIGN_W-1:0]        in_alignment,
  input  logic                                in_page_offered,
  input  logic [scba_pkg::ADDR_BITS-1:0]      in_page_base,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic [scba_pkg::ADDR_BITS-1:0]      out_address,
  output logic [scba_pkg::CLS_W-1:0]          out_size_class,
  output logic [scba_pkg::REQ_W-1:0]          out_object_size
);

  scba_pkg::cmd_t cmd;

  scba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  scba_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_request_bytes (in_request_bytes),
    .in_alignment     (in_alignment),
    .in_page_offered  (in_page_offered),
    .in_page_base     (in_page_base),
    .out_status       (out_status),
    .out_address      (out_address),
    .out_size_class   (out_size_class),
    .out_object_size  (out_object_size)
  );

`ifndef NO_ASSERTIONS
  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("Result register overwritten while its beat was stalled.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && out_valid == $past(out_valid && out_stall)))
    else $error("Second request taken before the first was finished.");

  a_commit_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("Finished request produced no result beat.");

  a_oom_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == scba_pkg::ST_OOM) |-> (out_address == '0))
    else $error("Out-of-memory result carries a non-zero address.");
`endif

endmodule

// ----- sim/scba_result_checker.sv -----
// Result checker for the size-class bump allocator: predicts each result beat from the
// accepted request beats and compares it field by field. Depends on scba_pkg.
`timescale 1ns / 1ps

module scba_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [scba_pkg::REQ_W-1:0]     in_request_bytes,
  input  logic [scba_pkg::ALIGN_W-1:0]   in_alignment,
  input  logic                           in_page_offered,
  input  logic [scba_pkg::ADDR_BITS-1:0] in_page_base,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [1:0]                     out_status,
  input  logic [scba_pkg::ADDR_BITS-1:0] out_address,
  input  logic [scba_pkg::CLS_W-1:0]     out_size_class,
  input  logic [scba_pkg::REQ_W-1:0]     out_object_size,
  output int                             pending_grants,
  output int                             fail_count
);

  typedef struct {
    scba_pkg::status_t              status;
    logic [scba_pkg::ADDR_BITS-1:0] address;
    logic [scba_pkg::CLS_W-1:0]     size_class;
    logic [scba_pkg::REQ_W-1:0]     object_size;
  } grant_t;

  logic [scba_pkg::ADDR_BITS-1:0] free_top[scba_pkg::CLASS_COUNT];
  logic [scba_pkg::ADDR_BITS-1:0] page_floor[scba_pkg::CLASS_COUNT];
  grant_t                         grants_due[$];
  grant_t                         oldest;
  int                             bad = 0;

  function automatic int unsigned msb_index(input logic [scba_pkg::REQ_W-1:0] x);
    int unsigned n;
    n = 0;
    while (x > 1) begin
      x = x >> 1;
      n++;
    end
    return n;
  endfunction

  function automatic logic [scba_pkg::CLS_W-1:0] class_for(
      input logic [scba_pkg::REQ_W-1:0] req);
    int unsigned s;
    int unsigned e;
    int unsigned step;
    int unsigned rounded;
    int unsigned cls;
    if (req <= scba_pkg::SMALL_LIMIT) begin
      s = (req <= 1) ? 0 : msb_index(req - 1) + 1;
      cls = (s > scba_pkg::BASE_SHIFT) ? s - scba_pkg::BASE_SHIFT : 0;
    end else begin
      e = msb_index(req - 1);
      step = 1 << (e - 2);
      rounded = (req + step - 1) & ~(step - 1);
      cls = scba_pkg::SMALL_CLS_COUNT + (e - scba_pkg::SMALL_LOG2) * 4
            + (rounded >> (e - 2)) - 5;
    end
    if (cls > scba_pkg::CLASS_COUNT - 1) cls = scba_pkg::CLASS_COUNT - 1;
    return scba_pkg::CLS_W'(cls);
  endfunction

  function automatic logic [scba_pkg::REQ_W-1:0] class_bytes(
      input logic [scba_pkg::CLS_W-1:0] cls);
    int unsigned i;
    if (cls < scba_pkg::SMALL_CLS_COUNT) begin
      return scba_pkg::REQ_W'(1) << (cls + scba_pkg::BASE_SHIFT);
    end
    i = cls - scba_pkg::SMALL_CLS_COUNT;
    return scba_pkg::REQ_W'(5 + i % 4) << (scba_pkg::SMALL_LOG2 + i / 4 - 2);
  endfunction

  task automatic allot(input logic [scba_pkg::REQ_W-1:0] bytes,
                       input logic [scba_pkg::ALIGN_W-1:0] align,
                       input logic offered,
                       input logic [scba_pkg::ADDR_BITS-1:0] base);
    logic [scba_pkg::ALIGN_W-1:0] al;
    logic [scba_pkg::REQ_W-1:0]   req;
    logic [scba_pkg::CLS_W-1:0]   c;
    logic [scba_pkg::REQ_W-1:0]   sz;
    grant_t                       g;
    al = (align > scba_pkg::ALIGN_W'(scba_pkg::SMALL_LIMIT)) ?
         scba_pkg::ALIGN_W'(scba_pkg::SMALL_LIMIT) : align;
    req = (bytes > scba_pkg::REQ_W'(al)) ? bytes : scba_pkg::REQ_W'(al);
    g.address = '0;
    if (req > scba_pkg::ALLOC_CAP) begin
      g.status = scba_pkg::ST_OOM;
      g.size_class = scba_pkg::CLS_W'(scba_pkg::CLASS_COUNT - 1);
      g.object_size = scba_pkg::REQ_W'(scba_pkg::ALLOC_CAP);
    end else begin
      c = class_for(req);
      sz = class_bytes(c);
      g.size_class = c;
      g.object_size = sz;
      if (scba_pkg::ADDR_BITS'(free_top[c] - page_floor[c]) >=
          scba_pkg::ADDR_BITS'(sz)) begin
        free_top[c] = free_top[c] - scba_pkg::ADDR_BITS'(sz);
        g.address = free_top[c];
        g.status = scba_pkg::ST_CURSOR;
      end else if (offered) begin
        page_floor[c] = base;
        free_top[c] = base + scba_pkg::ADDR_BITS'(scba_pkg::PAGE_SPAN)
                      - scba_pkg::ADDR_BITS'(sz);
        g.address = free_top[c];
        g.status = scba_pkg::ST_REFILL;
      end else begin
        g.status = scba_pkg::ST_OOM;
      end
    end
    grants_due.push_back(g);
  endtask

  task automatic flag(input string field, input logic [scba_pkg::ADDR_BITS-1:0] want,
                      input logic [scba_pkg::ADDR_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      bad++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < scba_pkg::CLASS_COUNT; k++) begin
        free_top[k] = '0;
        page_floor[k] = '0;
      end
      grants_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        allot(in_request_bytes, in_alignment, in_page_offered, in_page_base);
      end
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          $error("result beat with no request outstanding");
          bad++;
        end else begin
          oldest = grants_due.pop_front();
          flag("status", scba_pkg::ADDR_BITS'(oldest.status),
               scba_pkg::ADDR_BITS'(out_status));
          flag("address", oldest.address, out_address);
          flag("size_class", scba_pkg::ADDR_BITS'(oldest.size_class),
               scba_pkg::ADDR_BITS'(out_size_class));
          flag("object_size", scba_pkg::ADDR_BITS'(oldest.object_size),
               scba_pkg::ADDR_BITS'(out_object_size));
        end
      end
    end
    pending_grants <= grants_due.size();
    fail_count <= bad;
  end

endmodule

// ----- sim/size_class_bump_allocator_tb.sv -----
// Testbench top for the size-class bump allocator: clock, reset, request stimulus with
// random idling on both channels, watchdog and verdict. Depends on scba_pkg, the block
// and scba_result_checker.
`timescale 1ns / 1ps

module size_class_bump_allocator_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1650;

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  logic [scba_pkg::REQ_W-1:0]         in_request_bytes;
  logic [scba_pkg::ALIGN_W-1:0]       in_alignment;
  logic                               in_page_offered;
  logic [scba_pkg::ADDR_BITS-1:0]     in_page_base;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [1:0]                         out_status;
  logic [scba_pkg::ADDR_BITS-1:0]     out_address;
  logic [scba_pkg::CLS_W-1:0]         out_size_class;
  logic [scba_pkg::REQ_W-1:0]         out_object_size;
  int                                 pending_grants;
  int                                 fail_count;
  bit                                 calm = 1'b0;
  int                                 stall_hold = 0;
  int                                 quiet_cycles = 0;

  size_class_bump_allocator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_request_bytes (in_request_bytes),
    .in_alignment     (in_alignment),
    .in_page_offered  (in_page_offered),
    .in_page_base     (in_page_base),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_address      (out_address),
    .out_size_class   (out_size_class),
    .out_object_size  (out_object_size)
  );

  scba_result_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_request_bytes (in_request_bytes),
    .in_alignment     (in_alignment),
    .in_page_offered  (in_page_offered),
    .in_page_base     (in_page_base),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_address      (out_address),
    .out_size_class   (out_size_class),
    .out_object_size  (out_object_size),
    .pending_grants   (pending_grants),
    .fail_count       (fail_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [scba_pkg::ADDR_BITS-1:0] any_base();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return 48'hFFFF_FFE0_0000;
      1: return r[47:0];
      default: return r[47:0] & ~48'h1F_FFFF;
    endcase
  endfunction

  function automatic logic [scba_pkg::REQ_W-1:0] any_bytes();
    int k;
    k = $urandom_range(0, 16);
    return scba_pkg::REQ_W'($urandom_range(0, 1 << k));
  endfunction

  function automatic logic [scba_pkg::ALIGN_W-1:0] any_align();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      4, 5, 6, 7: return scba_pkg::ALIGN_W'(1 << $urandom_range(0, 10));
      8: return scba_pkg::ALIGN_W'($urandom_range(0, 2047));
      default: return scba_pkg::ALIGN_W'($urandom_range(1025, 2047));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic offer_request(input logic [scba_pkg::REQ_W-1:0] bytes,
                               input logic [scba_pkg::ALIGN_W-1:0] align,
                               input logic offered,
                               input logic [scba_pkg::ADDR_BITS-1:0] base);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_request_bytes <= bytes;
    in_alignment <= align;
    in_page_offered <= offered;
    in_page_base <= base;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (!calm && !out_stall && $urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_hold <= idle_len();
    end else begin
      out_stall <= 1'b0;
      stall_hold <= $urandom_range(0, 5);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sent;
    int len;
    logic [scba_pkg::REQ_W-1:0] target;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_request_bytes = '0;
    in_alignment = '0;
    in_page_offered = 1'b0;
    in_page_base = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: empty classes, zero size, clamped alignment, cap and wrap-around.
    offer_request(17'd0, 11'd0, 1'b0, 48'h0);
    offer_request(17'd0, 11'd0, 1'b1, 48'h0);
    offer_request(17'd16, 11'd0, 1'b0, 48'h0);
    offer_request(17'd17, 11'd0, 1'b0, 48'h0);
    offer_request(17'd1024, 11'd0, 1'b1, 48'hFFFF_FFFF_FFFF);
    offer_request(17'd1025, 11'd0, 1'b1, 48'hFFFF_FFE0_0000);
    offer_request(17'd1025, 11'd0, 1'b0, 48'h0);
    offer_request(17'd65536, 11'd2047, 1'b1, 48'h1234_5660_0000);
    offer_request(17'd65536, 11'd0, 1'b0, 48'h0);
    offer_request(17'd65537, 11'd0, 1'b1, 48'h0000_0020_0000);
    offer_request(17'h1FFFF, 11'h7FF, 1'b1, 48'hFFFF_FFFF_FFFF);
    offer_request(17'd0, 11'd2047, 1'b0, 48'h0);
    offer_request(17'd1, 11'd1025, 1'b0, 48'h0);
    offer_request(17'd0, 11'd1024, 1'b0, 48'h0);
    offer_request(17'd1, 11'd1, 1'b0, 48'h0);
    offer_request(17'd49152, 11'd0, 1'b1, 48'hABCD_EF01_2345);
    offer_request(17'd40961, 11'd512, 1'b1, 48'h0000_0040_0000);
    offer_request(17'd32768, 11'd0, 1'b0, 48'h0);
    offer_request(17'd2049, 11'd1024, 1'b1, 48'h5555_5540_0000);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 6) == 0) calm <= ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19)) inside
        [0:11]: begin
          // Runs near one large size, mostly in one class, so that its page empties and must be refilled.
          target = $urandom_range(0, 1) ? scba_pkg::REQ_W'($urandom_range(32769, 65536))
                                       : scba_pkg::REQ_W'($urandom_range(12288, 32768));
          len = $urandom_range(8, 40);
          repeat (len) begin
            offer_request(target - scba_pkg::REQ_W'($urandom_range(0, 255)),
                          $urandom_range(0, 3) == 0 ? any_align() : '0,
                          $urandom_range(0, 9) < 7, any_base());
          end
          sent += len;
        end
        [12:16]: begin
          offer_request(any_bytes(), any_align(), 1'($urandom_range(0, 1)), any_base());
          sent++;
        end
        default: begin
          offer_request(scba_pkg::REQ_W'($urandom_range(0, 131071)),
                        scba_pkg::ALIGN_W'($urandom_range(0, 2047)),
                        1'($urandom_range(0, 1)), any_base());
          sent++;
        end
      endcase
    end
    in_valid <= 1'b0;

    while (pending_grants != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
